FILE: rtl/core/grli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grli_pkg: shared types and constants
// Command codes, status codes, payload structs and reset values.
// ----------------------------------------------------------------------------
package grli_pkg;

    localparam int unsigned CHANNELS_DEF = 16;
    localparam int unsigned MAX_RES      = 16;

    localparam logic [3:0] CMD_TICK    = 4'd0;
    localparam logic [3:0] CMD_PING    = 4'd1;
    localparam logic [3:0] CMD_REPORT  = 4'd2;
    localparam logic [3:0] CMD_SAFE    = 4'd3;
    localparam logic [3:0] CMD_FACTORY = 4'd4;
    localparam logic [3:0] CMD_CH_CFG  = 4'd5;
    localparam logic [3:0] CMD_CH_SET  = 4'd6;
    localparam logic [3:0] CMD_CH_GET  = 4'd7;
    localparam logic [3:0] CMD_CH_REM  = 4'd8;
    localparam logic [3:0] CMD_LS_CFG  = 4'd9;
    localparam logic [3:0] CMD_ARM     = 4'd10;
    localparam logic [3:0] CMD_DISARM  = 4'd11;
    localparam logic [3:0] CMD_LS_OFF  = 4'd12;
    localparam logic [3:0] CMD_LS_SET  = 4'd13;
    localparam logic [3:0] CMD_LS_FRQ  = 4'd14;
    localparam logic [3:0] CMD_LS_STAT = 4'd15;

    localparam logic [4:0] ST_OK        = 5'd0;
    localparam logic [4:0] ST_PONG      = 5'd1;
    localparam logic [4:0] ST_CH_RPT    = 5'd2;
    localparam logic [4:0] ST_CH_UNCFG  = 5'd3;
    localparam logic [4:0] ST_NO_CH     = 5'd4;
    localparam logic [4:0] ST_LS_RPT    = 5'd5;
    localparam logic [4:0] ST_LS_UNRPT  = 5'd6;
    localparam logic [4:0] ST_BAD_CH    = 5'd7;
    localparam logic [4:0] ST_PIN_RANGE = 5'd8;
    localparam logic [4:0] ST_PIN_INPUT = 5'd9;
    localparam logic [4:0] ST_PIN_USED  = 5'd10;
    localparam logic [4:0] ST_PIN_LASER = 5'd11;
    localparam logic [4:0] ST_PIN_RELAY = 5'd12;
    localparam logic [4:0] ST_FRQ_RANGE = 5'd13;
    localparam logic [4:0] ST_CEIL_RNG  = 5'd14;
    localparam logic [4:0] ST_LS_UNCFG  = 5'd15;
    localparam logic [4:0] ST_NOT_ARMED = 5'd16;
    localparam logic [4:0] ST_DUTY_RNG  = 5'd17;
    localparam logic [4:0] ST_DUTY_CEIL = 5'd18;
    localparam logic [4:0] ST_WDOG      = 5'd19;

    localparam logic [2:0] REG_WDOG  = 3'd0;
    localparam logic [2:0] REG_FMIN  = 3'd1;
    localparam logic [2:0] REG_FMAX  = 3'd2;
    localparam logic [2:0] REG_MAXP  = 3'd3;
    localparam logic [2:0] REG_IOLO  = 3'd4;
    localparam logic [2:0] REG_IOHI  = 3'd5;

    localparam logic [15:0] WDOG_RST = 16'd2000;
    localparam logic [15:0] FMIN_RST = 16'd100;
    localparam logic [15:0] FMAX_RST = 16'd40000;
    localparam logic [5:0]  MAXP_RST = 6'd39;
    localparam logic [5:0]  IOLO_RST = 6'd34;
    localparam logic [5:0]  IOHI_RST = 6'd39;
    localparam logic [15:0] LFRQ_RST = 16'd1000;
    localparam logic [6:0]  PCT_FULL = 7'd100;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [4:0]  channel_number;
        logic [5:0]  pin_number;
        logic        polarity_high;
        logic        safe_on;
        logic        turn_on;
        logic [6:0]  percent;
        logic [15:0] freq_hz;
    } t_in;

    typedef struct packed {
        logic [4:0]  status;
        logic [4:0]  channel_out;
        logic [5:0]  pin_out;
        logic        polarity_out;
        logic        safe_out;
        logic        state_out;
        logic        armed_out;
        logic [6:0]  duty_percent_out;
        logic [7:0]  duty_raw_out;
        logic [15:0] freq_out;
        logic [6:0]  max_duty_out;
        logic        last;
    } t_out;

    // pct*255/100 for pct 0..100: multiply by 1336965 (just above 255*2^19/100), keep bits 26:19
    function automatic logic [7:0] duty_raw(input logic [6:0] pct);
        logic [27:0] m;
        begin
            m = {21'd0, pct} * 28'd1336965;
            return m[26:19];
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/grli_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grli_front: command intake
// Accepts requests and queues them for execution.
// ----------------------------------------------------------------------------
module grli_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire grli_pkg::t_in i_data,
    output logic               o_q_valid,
    input  wire logic          i_q_ready,
    output grli_pkg::t_in      o_q_data
);
    import grli_pkg::*;

    t_in         r_q_data [2];
    logic [1:0]  r_cnt, n_cnt;
    logic        r_wp, r_rp;
    logic        take, give;

    assign o_ready   = (r_cnt != 2'd2);
    assign take      = i_valid && o_ready;
    assign give      = o_q_valid && i_q_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_q_data[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, take} - {1'b0, give};
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q_data[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            if (take) r_wp <= ~r_wp;
            if (give) r_rp <= ~r_rp;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/grli_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grli_back: command execution
// Holds channel table and laser state, runs one request, emits results.
// ----------------------------------------------------------------------------
module grli_back #(
    parameter int unsigned CHANNELS = grli_pkg::CHANNELS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    output logic               o_q_ready,
    input  wire grli_pkg::t_in i_q_data,
    input  wire logic [15:0]   i_silence,
    input  wire logic          i_cfg_en,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output grli_pkg::t_out     o_data
);
    import grli_pkg::*;

    localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned KW = $clog2(MAX_RES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [15:0] r_wdog, r_fmin, r_fmax;
    logic [5:0]  r_maxp, r_iolo, r_iohi;

    logic [CHANNELS-1:0] r_cv;
    logic [5:0] r_cpin [CHANNELS];
    logic       r_cpol [CHANNELS];
    logic       r_csafe[CHANNELS];
    logic       r_ccur [CHANNELS];

    logic        r_lv, r_larm;
    logic [5:0]  r_lpin;
    logic [15:0] r_lfrq;
    logic [6:0]  r_lceil, r_lduty;

    logic [1:0]  r_state;
    logic [CW:0] r_idx;
    logic [KW-1:0] r_k;
    logic        r_ovalid;
    t_out        r_odata;
    // pending report entry held back until the next entry or the scan end shows if it is the last
    logic        r_pend;
    t_out        r_pdata;

    logic        chok;
    logic [CW-1:0] c;
    logic [CHANNELS-1:0] taken_other, taken_any;
    logic        pin_err_r, pin_err_i;
    logic        frq_bad;

    assign chok = (i_q_data.channel_number != 5'd0) &&
                  (32'(i_q_data.channel_number) <= CHANNELS);
    assign c = CW'(i_q_data.channel_number - 5'd1);

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            taken_any[i]   = r_cv[i] && (r_cpin[i] == i_q_data.pin_number);
            taken_other[i] = taken_any[i] && (CW'(i) != c);
        end
    end

    assign pin_err_r = i_q_data.pin_number > r_maxp;
    assign pin_err_i = (i_q_data.pin_number >= r_iolo) && (i_q_data.pin_number <= r_iohi);
    assign frq_bad   = (i_q_data.freq_hz < r_fmin) || (i_q_data.freq_hz > r_fmax);

    assign o_q_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid   = r_ovalid;
    assign o_data    = r_odata;

    // laser fields for a result, from given next laser state
    function automatic t_out mk(input logic [4:0] s, input logic lv, input logic arm,
                                input logic [6:0] duty, input logic [6:0] ceil,
                                input logic [15:0] frq);
        t_out o;
        logic [6:0] e;
        begin
            o = '0;
            e = arm ? duty : 7'd0;
            if (e > ceil) e = ceil;
            if (e > PCT_FULL) e = PCT_FULL;
            o.status = s;
            o.armed_out = arm;
            o.duty_percent_out = duty;
            o.duty_raw_out = lv ? duty_raw(e) : 8'd0;
            o.freq_out = frq;
            o.max_duty_out = ceil;
            return o;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        t_out o;
        logic lv_n, arm_n;
        logic [6:0] duty_n, ceil_n;
        logic [15:0] frq_n;
        logic [4:0] s;
        logic emit;
        lv_n = r_lv; arm_n = r_larm; duty_n = r_lduty; ceil_n = r_lceil; frq_n = r_lfrq;
        s = ST_OK; emit = 1'b1; o = '0;
        if (!i_rst_n) begin
            r_wdog <= WDOG_RST; r_fmin <= FMIN_RST; r_fmax <= FMAX_RST;
            r_maxp <= MAXP_RST; r_iolo <= IOLO_RST; r_iohi <= IOHI_RST;
            r_cv <= '0;
            r_lv <= 1'b0; r_larm <= 1'b0; r_lpin <= '0; r_lfrq <= LFRQ_RST;
            r_lceil <= PCT_FULL; r_lduty <= '0;
            r_state <= S_IDLE; r_ovalid <= 1'b0; r_pend <= 1'b0;
            r_idx <= '0; r_k <= '0;
        end else begin
            if (i_cfg_en) begin
                unique case (i_cfg_idx)
                    REG_WDOG: r_wdog <= i_cfg_data;
                    REG_FMIN: r_fmin <= i_cfg_data;
                    REG_FMAX: r_fmax <= i_cfg_data;
                    REG_MAXP: r_maxp <= i_cfg_data[5:0];
                    REG_IOLO: r_iolo <= i_cfg_data[5:0];
                    REG_IOHI: r_iohi <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && o_q_ready) begin
                        case (i_q_data.cmd)
                            CMD_TICK: begin
                                if (r_lv && r_larm && r_lduty != 7'd0 && i_silence > r_wdog) begin
                                    arm_n = 1'b0; duty_n = '0; s = ST_WDOG;
                                end else emit = 1'b0;
                            end
                            CMD_PING: s = ST_PONG;
                            CMD_REPORT: begin
                                emit = 1'b0;
                                r_idx <= '0; r_k <= '0; r_pend <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            CMD_SAFE, CMD_FACTORY: begin
                                for (int i = 0; i < CHANNELS; i++)
                                    if (r_cv[i]) r_ccur[i] <= r_csafe[i];
                                if (i_q_data.cmd == CMD_FACTORY) r_cv <= '0;
                            end
                            CMD_CH_CFG: begin
                                if (!chok) s = ST_BAD_CH;
                                else if (pin_err_r) s = ST_PIN_RANGE;
                                else if (pin_err_i) s = ST_PIN_INPUT;
                                else if (|taken_other) s = ST_PIN_USED;
                                else if (r_lv && r_lpin == i_q_data.pin_number)
                                    s = ST_PIN_LASER;
                                else begin
                                    r_cv[c] <= 1'b1;
                                    r_cpin[c] <= i_q_data.pin_number;
                                    r_cpol[c] <= i_q_data.polarity_high;
                                    r_csafe[c] <= i_q_data.safe_on;
                                    r_ccur[c] <= i_q_data.safe_on;
                                end
                            end
                            CMD_CH_SET: begin
                                if (!chok || !r_cv[c]) s = ST_BAD_CH;
                                else r_ccur[c] <= i_q_data.turn_on;
                            end
                            CMD_CH_GET: begin
                                if (!chok) s = ST_BAD_CH;
                                else if (r_cv[c]) begin
                                    s = ST_CH_RPT;
                                    o.pin_out = r_cpin[c]; o.polarity_out = r_cpol[c];
                                    o.safe_out = r_csafe[c]; o.state_out = r_ccur[c];
                                    o.channel_out = i_q_data.channel_number;
                                end else begin
                                    s = ST_CH_UNCFG;
                                    o.channel_out = i_q_data.channel_number;
                                end
                            end
                            CMD_CH_REM: begin
                                if (!chok) s = ST_BAD_CH;
                                else if (r_cv[c]) begin
                                    r_ccur[c] <= r_csafe[c]; r_cv[c] <= 1'b0;
                                end
                            end
                            CMD_LS_CFG: begin
                                if (pin_err_r) s = ST_PIN_RANGE;
                                else if (pin_err_i) s = ST_PIN_INPUT;
                                else if (|taken_any) s = ST_PIN_RELAY;
                                else if (frq_bad) s = ST_FRQ_RANGE;
                                else if (i_q_data.percent > PCT_FULL) s = ST_CEIL_RNG;
                                else begin
                                    lv_n = 1'b1; r_lpin <= i_q_data.pin_number;
                                    frq_n = i_q_data.freq_hz; ceil_n = i_q_data.percent;
                                    arm_n = 1'b0; duty_n = '0;
                                end
                            end
                            CMD_ARM: begin
                                if (!r_lv) s = ST_LS_UNCFG; else arm_n = 1'b1;
                            end
                            CMD_DISARM: begin arm_n = 1'b0; duty_n = '0; end
                            CMD_LS_OFF: duty_n = '0;
                            CMD_LS_SET: begin
                                if (!r_lv) s = ST_LS_UNCFG;
                                else if (!r_larm) s = ST_NOT_ARMED;
                                else if (i_q_data.percent > PCT_FULL) s = ST_DUTY_RNG;
                                else if (i_q_data.percent > r_lceil) s = ST_DUTY_CEIL;
                                else duty_n = i_q_data.percent;
                            end
                            CMD_LS_FRQ: begin
                                if (!r_lv) s = ST_LS_UNCFG;
                                else if (frq_bad) s = ST_FRQ_RANGE;
                                else frq_n = i_q_data.freq_hz;
                            end
                            default: begin
                                if (!r_lv) s = ST_LS_UNRPT;
                                else begin s = ST_LS_RPT; o.pin_out = r_lpin; end
                            end
                        endcase
                        r_lv <= lv_n; r_larm <= arm_n; r_lduty <= duty_n;
                        r_lceil <= ceil_n; r_lfrq <= frq_n;
                        if (emit) begin
                            t_out b;
                            b = mk(s, lv_n, arm_n, duty_n, ceil_n, frq_n);
                            b.channel_out = o.channel_out; b.pin_out = o.pin_out;
                            b.polarity_out = o.polarity_out; b.safe_out = o.safe_out;
                            b.state_out = o.state_out; b.last = 1'b1;
                            r_odata <= b; r_ovalid <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    // one channel a cycle while not stalled; a found entry waits for the next
                    if (!r_pend || !r_ovalid || i_ready) begin
                        logic done;
                        done = (r_idx == (CW+1)'(CHANNELS)) || (r_k == KW'(MAX_RES));
                        if (done) begin
                            t_out b;
                            if (r_pend) begin
                                b = r_pdata; b.last = 1'b1;
                            end else begin
                                b = mk(ST_NO_CH, r_lv, r_larm, r_lduty, r_lceil, r_lfrq);
                                b.last = 1'b1;
                            end
                            r_odata <= b; r_ovalid <= 1'b1; r_state <= S_OUT;
                        end else begin
                            if (r_cv[r_idx[CW-1:0]]) begin
                                t_out b;
                                b = mk(ST_CH_RPT, r_lv, r_larm, r_lduty, r_lceil, r_lfrq);
                                b.channel_out = 5'(r_idx + 1'b1);
                                b.pin_out = r_cpin[r_idx[CW-1:0]];
                                b.polarity_out = r_cpol[r_idx[CW-1:0]];
                                b.safe_out = r_csafe[r_idx[CW-1:0]];
                                b.state_out = r_ccur[r_idx[CW-1:0]];
                                if (r_pend) begin
                                    r_odata <= r_pdata; r_ovalid <= 1'b1;
                                end
                                r_pdata <= b; r_pend <= 1'b1;
                                r_k <= r_k + 1'b1;
                            end
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/gpio_relay_laser_interlock.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_relay_laser_interlock: relay channel table and laser PWM interlock
// Command-driven controller with pin conflict checks and silence watchdog.
// ----------------------------------------------------------------------------
// Flow: a request is written into the intake queue, then executed with its result
//   registered; a new request leaves the queue only after the last result is accepted.
//   Report-all scans one channel per cycle unless the output stalls.
// Reset: synchronous active low; channel table empty, laser unconfigured.
module gpio_relay_laser_interlock #(
    parameter int unsigned CHANNELS = grli_pkg::CHANNELS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire grli_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output grli_pkg::t_out      o_data,
    input  wire logic           i_cfg_en,
    input  wire logic [2:0]     i_cfg_idx,
    input  wire logic [15:0]    i_cfg_data
);
    import grli_pkg::*;

    logic q_valid, q_ready;
    t_in  q_data;
    logic [15:0] r_sil;

    grli_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_data(q_data)
    );

    // silence count tracked at execution so it matches command order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sil <= '0;
        else if (q_valid && q_ready) begin
            if (q_data.cmd == CMD_TICK) begin
                if (r_sil != 16'hFFFF) r_sil <= r_sil + 16'd1;
            end else r_sil <= '0;
        end
    end

    grli_back #(.CHANNELS(CHANNELS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_data(q_data),
        .i_silence((r_sil != 16'hFFFF) ? r_sil + 16'd1 : r_sil),
        .i_cfg_en(i_cfg_en), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );
endmodule
`default_nettype wire

FILE: verif/tb_gpio_relay_laser_interlock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gpio_relay_laser_interlock: relay table and laser interlock testbench
// Drives command requests in bursts, stalls the result side on its own
// pattern, predicts every result from a behavioral copy of the block state
// and compares results field by field. Register settings change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_gpio_relay_laser_interlock;
    import grli_pkg::*;

    localparam int NCH = 16;
    localparam int WDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;
    logic        i_cfg_en = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    gpio_relay_laser_interlock DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_en(i_cfg_en), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [15:0] wd_timeout, fq_min, fq_max;
    logic [5:0]  pin_max, io_lo, io_hi;
    logic        ch_on [NCH];
    logic [5:0]  ch_pin [NCH];
    logic        ch_pol [NCH], ch_safe [NCH], ch_cur [NCH];
    logic        ls_on, ls_arm;
    logic [5:0]  ls_pin;
    logic [15:0] ls_freq, quiet_ticks;
    logic [6:0]  ls_ceil, ls_duty;

    t_in  cmd_queue[$];
    t_out result_queue[$];
    int   errors = 0, results_seen = 0, cmds_sent = 0, idle_cycles = 0;
    bit   sending = 1'b0;
    int   burst_left = 0, gap_left = 0, stall_phase = 0;

    task automatic reset_model();
        wd_timeout = WDOG_RST; fq_min = FMIN_RST; fq_max = FMAX_RST;
        pin_max = MAXP_RST; io_lo = IOLO_RST; io_hi = IOHI_RST;
        for (int i = 0; i < NCH; i++) begin
            ch_on[i] = 0; ch_pin[i] = 0; ch_pol[i] = 0; ch_safe[i] = 0; ch_cur[i] = 0;
        end
        ls_on = 0; ls_arm = 0; ls_pin = 0; ls_freq = LFRQ_RST;
        ls_ceil = PCT_FULL; ls_duty = 0; quiet_ticks = 0;
    endtask

    function automatic t_out laser_view(logic [4:0] st);
        t_out r;
        int eff;
        r = '0;
        r.status = st;
        eff = 0;
        if (ls_on) begin
            eff = ls_arm ? ls_duty : 0;
            if (eff > ls_ceil) eff = ls_ceil;
            if (eff > 100) eff = 100;
            eff = eff * 255 / 100;
        end
        r.armed_out = ls_arm;
        r.duty_percent_out = ls_duty;
        r.duty_raw_out = eff[7:0];
        r.freq_out = ls_freq;
        r.max_duty_out = ls_ceil;
        return r;
    endfunction

    task automatic push_status(logic [4:0] st);
        t_out r;
        r = laser_view(st);
        r.last = 1'b1;
        result_queue.push_back(r);
    endtask

    function automatic logic [4:0] pin_fault(logic [5:0] p);
        if (p > pin_max) return ST_PIN_RANGE;
        if (p >= io_lo && p <= io_hi) return ST_PIN_INPUT;
        return ST_OK;
    endfunction

    function automatic bit pin_held(logic [5:0] p, int skip);
        for (int i = 0; i < NCH; i++)
            if (i != skip && ch_on[i] && ch_pin[i] == p) return 1;
        return 0;
    endfunction

    task automatic predict_command(t_in c);
        t_out r;
        int k, idx;
        bit ch_ok;
        logic [4:0] e;
        ch_ok = c.channel_number >= 1 && c.channel_number <= NCH;
        idx = ch_ok ? c.channel_number - 1 : 0;
        if (c.cmd == CMD_TICK) begin
            if (quiet_ticks != 16'hFFFF) quiet_ticks++;
            if (ls_on && ls_arm && ls_duty > 0 && quiet_ticks > wd_timeout) begin
                ls_arm = 0; ls_duty = 0;
                push_status(ST_WDOG);
            end
            return;
        end
        quiet_ticks = 0;
        case (c.cmd)
            CMD_PING: push_status(ST_PONG);
            CMD_REPORT: begin
                k = 0;
                for (int i = 0; i < NCH; i++) begin
                    if (ch_on[i]) begin
                        r = laser_view(ST_CH_RPT);
                        r.channel_out = 5'(i + 1);
                        r.pin_out = ch_pin[i];
                        r.polarity_out = ch_pol[i];
                        r.safe_out = ch_safe[i];
                        r.state_out = ch_cur[i];
                        result_queue.push_back(r);
                        k++;
                    end
                end
                if (k == 0) push_status(ST_NO_CH);
                else result_queue[$].last = 1'b1;
            end
            CMD_SAFE, CMD_FACTORY: begin
                for (int i = 0; i < NCH; i++)
                    if (ch_on[i]) begin
                        ch_cur[i] = ch_safe[i];
                        if (c.cmd == CMD_FACTORY) ch_on[i] = 0;
                    end
                push_status(ST_OK);
            end
            CMD_CH_CFG: begin
                e = pin_fault(c.pin_number);
                if (!ch_ok) push_status(ST_BAD_CH);
                else if (e != ST_OK) push_status(e);
                else if (pin_held(c.pin_number, idx)) push_status(ST_PIN_USED);
                else if (ls_on && ls_pin == c.pin_number) push_status(ST_PIN_LASER);
                else begin
                    ch_on[idx] = 1; ch_pin[idx] = c.pin_number;
                    ch_pol[idx] = c.polarity_high; ch_safe[idx] = c.safe_on;
                    ch_cur[idx] = c.safe_on;
                    push_status(ST_OK);
                end
            end
            CMD_CH_SET: begin
                if (!ch_ok || !ch_on[idx]) push_status(ST_BAD_CH);
                else begin
                    ch_cur[idx] = c.turn_on;
                    push_status(ST_OK);
                end
            end
            CMD_CH_GET: begin
                if (!ch_ok) push_status(ST_BAD_CH);
                else begin
                    r = laser_view(ch_on[idx] ? ST_CH_RPT : ST_CH_UNCFG);
                    r.channel_out = c.channel_number;
                    if (ch_on[idx]) begin
                        r.pin_out = ch_pin[idx]; r.polarity_out = ch_pol[idx];
                        r.safe_out = ch_safe[idx]; r.state_out = ch_cur[idx];
                    end
                    r.last = 1'b1;
                    result_queue.push_back(r);
                end
            end
            CMD_CH_REM: begin
                if (!ch_ok) push_status(ST_BAD_CH);
                else begin
                    if (ch_on[idx]) begin
                        ch_cur[idx] = ch_safe[idx]; ch_on[idx] = 0;
                    end
                    push_status(ST_OK);
                end
            end
            CMD_LS_CFG: begin
                e = pin_fault(c.pin_number);
                if (e != ST_OK) push_status(e);
                else if (pin_held(c.pin_number, -1)) push_status(ST_PIN_RELAY);
                else if (c.freq_hz < fq_min || c.freq_hz > fq_max) push_status(ST_FRQ_RANGE);
                else if (c.percent > 100) push_status(ST_CEIL_RNG);
                else begin
                    ls_on = 1; ls_pin = c.pin_number; ls_freq = c.freq_hz;
                    ls_ceil = c.percent; ls_arm = 0; ls_duty = 0;
                    push_status(ST_OK);
                end
            end
            CMD_ARM: begin
                if (!ls_on) push_status(ST_LS_UNCFG);
                else begin
                    ls_arm = 1;
                    push_status(ST_OK);
                end
            end
            CMD_DISARM: begin
                ls_arm = 0; ls_duty = 0;
                push_status(ST_OK);
            end
            CMD_LS_OFF: begin
                ls_duty = 0;
                push_status(ST_OK);
            end
            CMD_LS_SET: begin
                if (!ls_on) push_status(ST_LS_UNCFG);
                else if (!ls_arm) push_status(ST_NOT_ARMED);
                else if (c.percent > 100) push_status(ST_DUTY_RNG);
                else if (c.percent > ls_ceil) push_status(ST_DUTY_CEIL);
                else begin
                    ls_duty = c.percent;
                    push_status(ST_OK);
                end
            end
            CMD_LS_FRQ: begin
                if (!ls_on) push_status(ST_LS_UNCFG);
                else if (c.freq_hz < fq_min || c.freq_hz > fq_max) push_status(ST_FRQ_RANGE);
                else begin
                    ls_freq = c.freq_hz;
                    push_status(ST_OK);
                end
            end
            default: begin
                if (!ls_on) push_status(ST_LS_UNRPT);
                else begin
                    r = laser_view(ST_LS_RPT);
                    r.pin_out = ls_pin;
                    r.last = 1'b1;
                    result_queue.push_back(r);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    // driver: bursts of requests with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_command(i_data);
                cmds_sent++;
            end
            if (!(i_valid && !o_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (sending && cmd_queue.size() > 0) begin
                    i_data <= cmd_queue.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall pattern on the result side plus compare
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (result_queue.size() == 0) begin
                    report_mismatch("unexpected result status", o_data.status, -1);
                end else begin
                    want = result_queue.pop_front();
                    if (o_data.status != want.status)
                        report_mismatch("status", o_data.status, want.status);
                    if (o_data.channel_out != want.channel_out)
                        report_mismatch("channel_out", o_data.channel_out, want.channel_out);
                    if (o_data.pin_out != want.pin_out)
                        report_mismatch("pin_out", o_data.pin_out, want.pin_out);
                    if (o_data.polarity_out != want.polarity_out)
                        report_mismatch("polarity_out", o_data.polarity_out, want.polarity_out);
                    if (o_data.safe_out != want.safe_out)
                        report_mismatch("safe_out", o_data.safe_out, want.safe_out);
                    if (o_data.state_out != want.state_out)
                        report_mismatch("state_out", o_data.state_out, want.state_out);
                    if (o_data.armed_out != want.armed_out)
                        report_mismatch("armed_out", o_data.armed_out, want.armed_out);
                    if (o_data.duty_percent_out != want.duty_percent_out)
                        report_mismatch("duty_percent_out", o_data.duty_percent_out,
                                        want.duty_percent_out);
                    if (o_data.duty_raw_out != want.duty_raw_out)
                        report_mismatch("duty_raw_out", o_data.duty_raw_out, want.duty_raw_out);
                    if (o_data.freq_out != want.freq_out)
                        report_mismatch("freq_out", o_data.freq_out, want.freq_out);
                    if (o_data.max_duty_out != want.max_duty_out)
                        report_mismatch("max_duty_out", o_data.max_duty_out, want.max_duty_out);
                    if (o_data.last != want.last)
                        report_mismatch("last", o_data.last, want.last);
                end
            end
            // stall windows of varying length; while bit 8 of the phase counter is set, no stall at all
            stall_phase <= stall_phase + 1;
            if (stall_phase[8])
                i_ready <= 1'b1;
            else
                i_ready <= (stall_phase % 7 < 4) || ($urandom_range(0, 2) == 0);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Timeout with %0d results pending", result_queue.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_in make_cmd(logic [3:0] op, int chn, int pin, int pct, int frq);
        t_in c;
        c = '0;
        c.cmd = op;
        c.channel_number = 5'(chn);
        c.pin_number = 6'(pin);
        c.percent = 7'(pct);
        c.freq_hz = 16'(frq);
        c.polarity_high = 1'($urandom_range(0, 1));
        c.safe_on = 1'($urandom_range(0, 1));
        c.turn_on = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic t_in random_cmd();
        t_in c;
        int sel;
        c = t_in'($bits(t_in)'({$urandom, $urandom}));
        sel = $urandom_range(0, 9);
        // mostly legal channels, pins and frequencies; some raw noise
        if (sel < 8) begin
            c.channel_number = 5'($urandom_range(1, 16));
            c.pin_number = 6'($urandom_range(0, 40));
            c.freq_hz = 16'($urandom_range(50, 45000));
            c.percent = 7'($urandom_range(0, 110));
        end
        if (sel < 3) c.cmd = CMD_TICK;
        else if (sel == 3) c.cmd = CMD_CH_CFG;
        return c;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_en <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_en <= 1'b0;
        case (idx)
            REG_WDOG: wd_timeout = val;
            REG_FMIN: fq_min = val;
            REG_FMAX: fq_max = val;
            REG_MAXP: pin_max = val[5:0];
            REG_IOLO: io_lo = val[5:0];
            default:  io_hi = val[5:0];
        endcase
    endtask

    task automatic run_phase(int n_random);
        for (int i = 0; i < n_random; i++) cmd_queue.push_back(random_cmd());
        sending = 1'b1;
        wait (cmd_queue.size() == 0 && !i_valid);
        wait (result_queue.size() == 0);
        sending = 1'b0;
        // ticks may produce nothing; let the pipeline drain
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_ready <= 1'b1;

        // directed: empty report, unconfigured laser, bad channels, pin edges
        cmd_queue.push_back(make_cmd(CMD_REPORT, 1, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_LS_STAT, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_ARM, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_DISARM, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_LS_OFF, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_CH_CFG, 0, 5, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_CH_CFG, 31, 5, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_CH_CFG, 1, 63, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_CH_CFG, 1, 34, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_CH_CFG, 1, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_CH_CFG, 1, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_CH_CFG, 16, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_CH_SET, 2, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_CH_REM, 3, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_LS_CFG, 0, 0, 50, 1000));
        cmd_queue.push_back(make_cmd(CMD_LS_CFG, 0, 33, 50, 99));
        cmd_queue.push_back(make_cmd(CMD_LS_CFG, 0, 33, 127, 1000));
        cmd_queue.push_back(make_cmd(CMD_LS_CFG, 0, 33, 60, 40000));
        cmd_queue.push_back(make_cmd(CMD_CH_CFG, 5, 33, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_LS_SET, 0, 0, 30, 0));
        cmd_queue.push_back(make_cmd(CMD_ARM, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_LS_SET, 0, 0, 101, 0));
        cmd_queue.push_back(make_cmd(CMD_LS_SET, 0, 0, 61, 0));
        cmd_queue.push_back(make_cmd(CMD_LS_SET, 0, 0, 60, 0));
        cmd_queue.push_back(make_cmd(CMD_LS_FRQ, 0, 0, 0, 65535));
        run_phase(0);

        // short watchdog, trip by ticks
        write_reg(REG_WDOG, 16'd3);
        for (int i = 0; i < 5; i++) cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_ARM, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_LS_SET, 0, 0, 40, 0));
        run_phase(40);

        // extreme registers, inverted input-only range
        write_reg(REG_FMIN, 16'd1);
        write_reg(REG_FMAX, 16'd65535);
        write_reg(REG_MAXP, 16'd63);
        write_reg(REG_IOLO, 16'd63);
        write_reg(REG_IOHI, 16'd0);
        write_reg(REG_WDOG, 16'd65535);
        run_phase(35);

        write_reg(REG_FMIN, 16'd30000);
        write_reg(REG_FMAX, 16'd1);
        write_reg(REG_MAXP, 16'd0);
        write_reg(REG_IOLO, 16'd0);
        write_reg(REG_IOHI, 16'd63);
        write_reg(REG_WDOG, 16'd1);
        run_phase(15);

        write_reg(REG_FMIN, 16'd100);
        write_reg(REG_FMAX, 16'd40000);
        write_reg(REG_MAXP, 16'd39);
        write_reg(REG_IOLO, 16'd34);
        write_reg(REG_IOHI, 16'd39);
        write_reg(REG_WDOG, 16'd2);
        run_phase(30);

        $display("Sent %0d commands and checked %0d results across five register settings",
                 cmds_sent, results_seen);
        if (errors == 0 && result_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/grli_pkg.sv
rtl/core/grli_front.sv
rtl/core/grli_back.sv
rtl/core/gpio_relay_laser_interlock.sv
verif/tb_gpio_relay_laser_interlock.sv
